>>> hw/rtl/arlp_pkg.sv
// arlp_pkg: shared widths, codes and control types for the auto-range light to pwm unit
// no dependencies; imported by every module of the block
package arlp_pkg;

  localparam int SAMPLE_BITS   = 10;
  localparam int LEVEL_BITS    = 8;
  localparam int DIVIDEND_BITS = SAMPLE_BITS + LEVEL_BITS;
  localparam int PROD_BITS     = 2 * LEVEL_BITS;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 8;

  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE   = {SAMPLE_BITS{1'b1}};
  localparam logic [SAMPLE_BITS-1:0] LIMIT_MARGIN = SAMPLE_BITS'(5);
  localparam logic [SAMPLE_BITS-1:0] LIMIT_HIGH   = FULL_SCALE - LIMIT_MARGIN;
  localparam logic [LEVEL_BITS-1:0]  LEVEL_MAX    = {LEVEL_BITS{1'b1}};
  localparam logic [LEVEL_BITS-1:0]  THR_RESET    = LEVEL_BITS'(55);

  localparam logic [CFG_IDX_BITS-1:0] CFG_INVERT    = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 1'b1;

  typedef enum logic {
    DIV_NORM,
    DIV_STRETCH
  } div_op_e;

  typedef struct packed {
    logic    capture;
    logic    div_start;
    div_op_e div_op;
    logic    lvl_calc;
    logic    sq_calc;
    logic    out_load;
  } arlp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } arlp_stat_t;

endpackage

>>> hw/rtl/arlp_div.sv
// arlp_div: restoring divider, one quotient bit per cycle
// needs arlp_pkg; the quotient must fit in LEVEL_BITS (dividend < divisor * 256)
module arlp_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [arlp_pkg::DIVIDEND_BITS-1:0]  dividend_i,
  input  logic [arlp_pkg::SAMPLE_BITS-1:0]    divisor_i,
  output logic                                busy_o,
  output logic                                done_o,
  output logic [arlp_pkg::LEVEL_BITS-1:0]     quotient_o
);
  import arlp_pkg::*;

  localparam int CNT_BITS = $clog2(LEVEL_BITS);
  localparam logic [CNT_BITS-1:0] STEP_LAST = CNT_BITS'(LEVEL_BITS - 1);

  logic                    busy_q;
  logic [CNT_BITS-1:0]     cnt_q;
  logic [SAMPLE_BITS-1:0]  rem_q, rem_d;
  logic [LEVEL_BITS-1:0]   low_q;
  logic [SAMPLE_BITS-1:0]  den_q;
  logic [SAMPLE_BITS:0]    trial;
  logic [SAMPLE_BITS:0]    diff;
  logic                    qbit;

  always_comb begin
    trial = {rem_q, low_q[LEVEL_BITS-1]};
    diff  = trial - {1'b0, den_q};
    qbit  = (trial >= {1'b0, den_q});
    rem_d = qbit ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_BITS'(1);
      if (cnt_q == STEP_LAST) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= dividend_i[DIVIDEND_BITS-1:LEVEL_BITS];
      low_q <= dividend_i[LEVEL_BITS-1:0];
      den_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      low_q <= {low_q[LEVEL_BITS-2:0], qbit};
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = busy_q && (cnt_q == STEP_LAST);
  assign quotient_o = low_q;

  a_no_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_done_ends : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_q)
    else $error("divider still busy after last step");

  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && den_q != '0) |-> (rem_q < den_q))
    else $error("partial remainder not below divisor");

endmodule

>>> hw/rtl/arlp_datapath.sv
// arlp_datapath: range tracking, scaling, invert, threshold, squaring, shared divider and output register
// needs arlp_pkg and arlp_div; driven by arlp_ctrl through arlp_cmd_t
module arlp_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  arlp_pkg::arlp_cmd_t                 cmd_i,
  output arlp_pkg::arlp_stat_t                stat_o,
  input  logic                                cfg_we_i,
  input  logic [arlp_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [arlp_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic [arlp_pkg::SAMPLE_BITS-1:0]    light_sample_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [arlp_pkg::LEVEL_BITS-1:0]     brightness_o,
  output logic [arlp_pkg::LEVEL_BITS-1:0]     stretched_level_o,
  output logic [arlp_pkg::SAMPLE_BITS-1:0]    lowest_seen_o,
  output logic [arlp_pkg::SAMPLE_BITS-1:0]    highest_seen_o,
  output logic                                near_limit_o
);
  import arlp_pkg::*;

  logic                     invert_q;
  logic [LEVEL_BITS-1:0]    thr_q;
  logic [SAMPLE_BITS-1:0]   min_q, max_q;
  logic                     near_q;
  logic [DIVIDEND_BITS-1:0] num_q;
  logic [SAMPLE_BITS-1:0]   span_q;
  logic [PROD_BITS-1:0]     lvlprod_q;
  logic [LEVEL_BITS-1:0]    ceil_q;
  logic [LEVEL_BITS-1:0]    str_q;
  logic [PROD_BITS-1:0]     sqr_q;
  logic                     out_valid_q;

  logic [SAMPLE_BITS-1:0]   min_d, max_d, diff, span_raw;
  logic [DIVIDEND_BITS-1:0] div_num;
  logic [SAMPLE_BITS-1:0]   div_den;
  logic                     div_busy, div_done;
  logic [LEVEL_BITS-1:0]    quot;
  logic [LEVEL_BITS-1:0]    lvl_a, lvl_b, lvl_c, ceil_d, str_d;
  logic [PROD_BITS-1:0]     bright_sum;
  logic [LEVEL_BITS-1:0]    bright_d;

  // range update and scaling numerator
  always_comb begin
    min_d    = (light_sample_i < min_q) ? light_sample_i : min_q;
    max_d    = (light_sample_i > max_q) ? light_sample_i : max_q;
    diff     = light_sample_i - min_d;
    span_raw = max_d - min_d;
  end

  // invert, threshold and clamp
  always_comb begin
    lvl_a  = invert_q ? (LEVEL_MAX - quot) : quot;
    ceil_d = LEVEL_MAX - thr_q;
    lvl_b  = (lvl_a > thr_q) ? (lvl_a - thr_q) : '0;
    lvl_c  = (lvl_b > ceil_d) ? ceil_d : lvl_b;
    str_d  = (ceil_q == '0) ? '0 : quot;
  end

  // square over 255 by shift and add, exact up to 255 * 255
  always_comb begin
    bright_sum = sqr_q + PROD_BITS'(1) + PROD_BITS'(sqr_q[PROD_BITS-1:LEVEL_BITS]);
    bright_d   = bright_sum[PROD_BITS-1:LEVEL_BITS];
  end

  always_comb begin
    unique case (cmd_i.div_op)
      DIV_NORM: begin
        div_num = num_q;
        div_den = span_q;
      end
      DIV_STRETCH: begin
        div_num = DIVIDEND_BITS'(lvlprod_q);
        div_den = SAMPLE_BITS'(ceil_q);
      end
    endcase
  end

  arlp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q    <= 1'b1;
      thr_q       <= THR_RESET;
      min_q       <= FULL_SCALE;
      max_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_INVERT:    invert_q <= cfg_data_i[0];
          CFG_THRESHOLD: thr_q    <= cfg_data_i[LEVEL_BITS-1:0];
          default: ;
        endcase
      end
      if (cmd_i.capture) begin
        min_q <= min_d;
        max_q <= max_d;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      near_q <= (light_sample_i < LIMIT_MARGIN) || (light_sample_i > LIMIT_HIGH);
      num_q  <= DIVIDEND_BITS'(diff) * DIVIDEND_BITS'(LEVEL_MAX);
      span_q <= (span_raw == '0) ? SAMPLE_BITS'(1) : span_raw;
    end
    if (cmd_i.lvl_calc) begin
      lvlprod_q <= PROD_BITS'(lvl_c) * PROD_BITS'(LEVEL_MAX);
      ceil_q    <= ceil_d;
    end
    if (cmd_i.sq_calc) begin
      str_q <= str_d;
      sqr_q <= PROD_BITS'(str_d) * PROD_BITS'(str_d);
    end
    if (cmd_i.out_load) begin
      brightness_o      <= bright_d;
      stretched_level_o <= str_q;
      lowest_seen_o     <= min_q;
      highest_seen_o    <= max_q;
      near_limit_o      <= near_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign stat_o.div_done = div_done;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  a_range_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (lowest_seen_o <= highest_seen_o))
    else $error("reported minimum above maximum");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("output register overwritten before it was taken");

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.capture || cmd_i.out_load) |-> !div_busy)
    else $error("capture or output load while divider busy");

endmodule

>>> hw/rtl/arlp_ctrl.sv
// arlp_ctrl: sequencer for one sample: capture, scaling divide, level step, stretch divide, squaring, output load
// needs arlp_pkg; commands arlp_datapath through arlp_cmd_t
module arlp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  arlp_pkg::arlp_stat_t stat_i,
  output arlp_pkg::arlp_cmd_t  cmd_o
);
  import arlp_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_NORM_GO  = 3'd1;
  localparam logic [2:0] ST_NORM_WT  = 3'd2;
  localparam logic [2:0] ST_LVL      = 3'd3;
  localparam logic [2:0] ST_STR_GO   = 3'd4;
  localparam logic [2:0] ST_STR_WT   = 3'd5;
  localparam logic [2:0] ST_SQ       = 3'd6;
  localparam logic [2:0] ST_DONE     = 3'd7;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d         = state_q;
    cmd_o           = '0;
    cmd_o.div_op    = DIV_NORM;
    in_ready_o      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_NORM_GO;
        end
      end
      ST_NORM_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_NORM;
        state_d         = ST_NORM_WT;
      end
      ST_NORM_WT: begin
        if (stat_i.div_done) state_d = ST_LVL;
      end
      ST_LVL: begin
        cmd_o.lvl_calc = 1'b1;
        state_d        = ST_STR_GO;
      end
      ST_STR_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_op    = DIV_STRETCH;
        state_d         = ST_STR_WT;
      end
      ST_STR_WT: begin
        if (stat_i.div_done) state_d = ST_SQ;
      end
      ST_SQ: begin
        cmd_o.sq_calc = 1'b1;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_wait_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STR_WT && stat_i.div_done) |=> (state_q == ST_SQ))
    else $error("missed end of stretch divide");

  a_one_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.capture, cmd_o.div_start, cmd_o.lvl_calc, cmd_o.sq_calc,
              cmd_o.out_load}))
    else $error("more than one datapath command in a cycle");

  a_capture_next : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == ST_NORM_GO))
    else $error("capture not followed by scaling divide");

endmodule

>>> hw/rtl/auto_range_light_to_pwm_unit.sv
// auto_range_light_to_pwm_unit: top level, joins arlp_ctrl and arlp_datapath
// needs arlp_pkg, arlp_ctrl, arlp_datapath (which holds arlp_div)
//
//   channel  | handshake             | payload
//   ---------+-----------------------+-----------------------------------------------
//   input    | in_valid_i/in_ready_o | light_sample_i
//   result   | out_valid_o/out_ready_i | brightness_o stretched_level_o lowest_seen_o
//            |                       | highest_seen_o near_limit_o
//   config   | cfg_we_i              | cfg_index_i cfg_data_i
//
// one sample goes from accept to result valid through two passes through the
// shared restoring divider plus capture, threshold, squaring and output load steps
// one sample in flight; the next is accepted once the result sits in the output register
// a stalled result holds the sequencer in its last step until the output register frees
// reset: invert on, threshold 55, running minimum full scale, running maximum zero
module auto_range_light_to_pwm_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [arlp_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [arlp_pkg::CFG_DATA_BITS-1:0]  cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [arlp_pkg::SAMPLE_BITS-1:0]    light_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [arlp_pkg::LEVEL_BITS-1:0]     brightness_o,
  output logic [arlp_pkg::LEVEL_BITS-1:0]     stretched_level_o,
  output logic [arlp_pkg::SAMPLE_BITS-1:0]    lowest_seen_o,
  output logic [arlp_pkg::SAMPLE_BITS-1:0]    highest_seen_o,
  output logic                                near_limit_o
);
  import arlp_pkg::*;

  arlp_cmd_t  cmd;
  arlp_stat_t stat;

  arlp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  arlp_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .light_sample_i    (light_sample_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .brightness_o      (brightness_o),
    .stretched_level_o (stretched_level_o),
    .lowest_seen_o     (lowest_seen_o),
    .highest_seen_o    (highest_seen_o),
    .near_limit_o      (near_limit_o)
  );

endmodule
